// ===== rtl/qadd_pkg.sv =====
package qadd_pkg;

    localparam int PRE_SHIFT_DEF = 20;

    localparam int IN_W    = 8;               // int8 samples
    localparam int OFF_W   = 9;               // input offsets
    localparam int DIFF_W  = OFF_W + 1;       // offset + sample
    localparam int ROFF_W  = 8;               // result offset, clamp bounds
    localparam int MUL_W   = 31;              // Q31 multiplier field
    localparam int EXP_W   = 5;               // right shift field
    localparam int SCALE_W = MUL_W + EXP_W;
    localparam int ACC_W   = 32;
    localparam int CFG_W   = SCALE_W;         // widest register
    localparam int REG_IDX_W = 3;

    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1) << (MUL_W - 1);

    // pipeline stage map
    localparam int RS_STG    = 3;             // stages inside one rescale unit
    localparam int STG_OFF   = 0;
    localparam int STG_RSA   = 1;
    localparam int STG_SUM   = STG_RSA + RS_STG;
    localparam int STG_RSS   = STG_SUM + 1;
    localparam int STG_ROFF  = STG_RSS + RS_STG;
    localparam int STG_CLAMP = STG_ROFF + 1;
    localparam int NUM_STG   = STG_CLAMP + 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_OFFSET  = 3'd0,
        REG_SECOND_OFFSET = 3'd1,
        REG_RESULT_OFFSET = 3'd2,
        REG_FIRST_SCALE   = 3'd3,
        REG_SECOND_SCALE  = 3'd4,
        REG_SUM_SCALE     = 3'd5,
        REG_CLAMP_LOW     = 3'd6,
        REG_CLAMP_HIGH    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_STG-1:0] en;   // stage register loads
        logic [NUM_STG-1:0] vld;  // stage holds a transaction
    } t_pipe_ctl;

endpackage

// ===== rtl/qadd_pipe_ctl.sv =====
module qadd_pipe_ctl
    import qadd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] en;

    // a stage moves when it is empty or the stage after it moves, so
    // bubbles are squeezed out while the output is stalled
    always_comb begin
        en[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NUM_STG-1];
    assign o_ctl.en    = en;
    assign o_ctl.vld   = r_vld;

endmodule

// ===== rtl/qadd_rescale.sv =====
module qadd_rescale
    import qadd_pkg::*;
#(
    parameter int XW  = DIFF_W,
    parameter int LSH = PRE_SHIFT_DEF
)
(
    input  logic                    i_clk,
    input  logic [RS_STG-1:0]       i_en,
    input  logic signed [XW-1:0]    i_x,
    input  logic [SCALE_W-1:0]      i_scale,
    output logic signed [ACC_W-1:0] o_y
);

    localparam int PW  = XW + MUL_W + 1;
    localparam int FW0 = PW + LSH + 1;
    localparam int FW  = (FW0 > 2 * MUL_W + 1) ? FW0 : 2 * MUL_W + 1;
    localparam logic signed [FW-1:0] NUDGE = FW'(1) <<< (MUL_W - 1);

    logic signed [PW-1:0]    r_prod;
    logic signed [FW-1:0]    prod_ext;
    logic signed [FW-1:0]    nudged;
    logic signed [ACC_W-1:0] r_high;
    logic signed [ACC_W-1:0] q;
    logic [EXP_W-1:0]        e;
    logic [ACC_W-1:0]        mask;
    logic [ACC_W-1:0]        rem;
    logic [ACC_W-1:0]        thr;
    logic signed [ACC_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= i_x * $signed({1'b0, i_scale[MUL_W-1:0]});
        end
    end

    // the same nudge serves both signs: floor((p + 2^30) / 2^31) equals
    // the truncating divide of the sign-dependent nudge
    always_comb begin
        prod_ext = {{(FW - PW){r_prod[PW-1]}}, r_prod};
        nudged   = (prod_ext <<< LSH) + NUDGE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_high <= nudged[MUL_W +: ACC_W];
        end
    end

    // rounding right shift, ties away from zero
    always_comb begin
        e    = i_scale[SCALE_W-1:MUL_W];
        q    = r_high >>> e;
        mask = ~({ACC_W{1'b1}} << e);
        rem  = r_high & mask;
        thr  = (mask >> 1) + ACC_W'(r_high[ACC_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_y <= q + $signed(ACC_W'(rem > thr));
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/quantized_int8_elementwise_add_unit.sv =====
// Quantized int8 elementwise add. Each transaction carries one pair of int8
// elements; each element gets its offset, is shifted left by PRE_SHIFT and
// rescaled (rounding doubling high multiply, then rounding right shift), the
// two are summed with 32-bit saturation, the sum is rescaled the same way,
// the result offset is added and the value is clamped to [clamp_low,
// clamp_high] (clamp_high wins if the bounds cross). The pipeline has ten
// register stages: a transaction goes in every cycle while o_ready is high,
// and o_ready drops only when the output stalls with every stage full. Each
// stage advances when it is empty or its successor advances, so a stalled
// output still lets new transactions fill empty stages. Registers are written
// through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while the
// pipeline is empty.
module quantized_int8_elementwise_add_unit
    import qadd_pkg::*;
#(
    parameter int PRE_SHIFT = PRE_SHIFT_DEF
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_a_sample,
    input  logic signed [IN_W-1:0] i_b_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [IN_W-1:0] o_sum_sample,
    input  logic                   i_cfg_we,
    input  logic [REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_pipe_ctl ctl;

    logic signed [OFF_W-1:0]  r_first_offset;
    logic signed [OFF_W-1:0]  r_second_offset;
    logic signed [ROFF_W-1:0] r_result_offset;
    logic [SCALE_W-1:0]       r_first_scale;
    logic [SCALE_W-1:0]       r_second_scale;
    logic [SCALE_W-1:0]       r_sum_scale;
    logic signed [ROFF_W-1:0] r_clamp_low;
    logic signed [ROFF_W-1:0] r_clamp_high;

    logic signed [DIFF_W-1:0] r_da;
    logic signed [DIFF_W-1:0] r_db;
    logic signed [ACC_W-1:0]  sa;
    logic signed [ACC_W-1:0]  sb;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  r_sum;
    logic signed [ACC_W-1:0]  ss;
    logic signed [ACC_W:0]    r_roff;
    logic signed [ACC_W:0]    lo;
    logic signed [ACC_W:0]    hi;
    logic signed [ACC_W:0]    lo_clamped;
    logic signed [ACC_W:0]    clamped;
    logic signed [IN_W-1:0]   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_offset  <= '0;
            r_second_offset <= '0;
            r_result_offset <= '0;
            r_first_scale   <= SCALE_RST;
            r_second_scale  <= SCALE_RST;
            r_sum_scale     <= SCALE_RST;
            r_clamp_low     <= {1'b1, {(ROFF_W-1){1'b0}}};
            r_clamp_high    <= {1'b0, {(ROFF_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FIRST_OFFSET:  r_first_offset  <= i_cfg_data[OFF_W-1:0];
                REG_SECOND_OFFSET: r_second_offset <= i_cfg_data[OFF_W-1:0];
                REG_RESULT_OFFSET: r_result_offset <= i_cfg_data[ROFF_W-1:0];
                REG_FIRST_SCALE:   r_first_scale   <= i_cfg_data[SCALE_W-1:0];
                REG_SECOND_SCALE:  r_second_scale  <= i_cfg_data[SCALE_W-1:0];
                REG_SUM_SCALE:     r_sum_scale     <= i_cfg_data[SCALE_W-1:0];
                REG_CLAMP_LOW:     r_clamp_low     <= i_cfg_data[ROFF_W-1:0];
                REG_CLAMP_HIGH:    r_clamp_high    <= i_cfg_data[ROFF_W-1:0];
            endcase
        end
    end

    qadd_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_ctl       (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_OFF]) begin
            r_da <= DIFF_W'(r_first_offset) + DIFF_W'(i_a_sample);
            r_db <= DIFF_W'(r_second_offset) + DIFF_W'(i_b_sample);
        end
    end

    qadd_rescale #(.XW(DIFF_W), .LSH(PRE_SHIFT)) u_rs_a (
        .i_clk   (i_clk),
        .i_en    (ctl.en[STG_RSA +: RS_STG]),
        .i_x     (r_da),
        .i_scale (r_first_scale),
        .o_y     (sa)
    );

    qadd_rescale #(.XW(DIFF_W), .LSH(PRE_SHIFT)) u_rs_b (
        .i_clk   (i_clk),
        .i_en    (ctl.en[STG_RSA +: RS_STG]),
        .i_x     (r_db),
        .i_scale (r_second_scale),
        .o_y     (sb)
    );

    assign sum_wide = (ACC_W+1)'(sa) + (ACC_W+1)'(sb);

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_SUM]) begin
            if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
                r_sum <= sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                r_sum <= sum_wide[ACC_W-1:0];
            end
        end
    end

    qadd_rescale #(.XW(ACC_W), .LSH(0)) u_rs_sum (
        .i_clk   (i_clk),
        .i_en    (ctl.en[STG_RSS +: RS_STG]),
        .i_x     (r_sum),
        .i_scale (r_sum_scale),
        .o_y     (ss)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_ROFF]) begin
            r_roff <= (ACC_W+1)'(ss) + (ACC_W+1)'(r_result_offset);
        end
    end

    // low bound first, then high, so crossed bounds give clamp_high
    always_comb begin
        lo         = (ACC_W+1)'(r_clamp_low);
        hi         = (ACC_W+1)'(r_clamp_high);
        lo_clamped = (r_roff < lo) ? lo : r_roff;
        clamped    = (lo_clamped > hi) ? hi : lo_clamped;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[STG_CLAMP]) begin
            r_out <= clamped[IN_W-1:0];
        end
    end

    assign o_sum_sample = r_out;

`ifndef SYNTH
    // an accepted transaction lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ctl.vld[STG_OFF])
        else $error("accepted transaction missing from first stage");

    // a stage that holds a transaction and does not move keeps it
    a_hold_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((ctl.vld & ~ctl.en) != '0))
        |=> ((ctl.vld & $past(ctl.vld & ~ctl.en)) == $past(ctl.vld & ~ctl.en)))
        else $error("stalled stage dropped its transaction");

    // the output stage can only fill from the stage before it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ctl.en[STG_CLAMP] && !ctl.vld[STG_ROFF])
        |=> !ctl.vld[STG_CLAMP])
        else $error("output stage filled from an empty stage");
`endif

endmodule
